FILE: rtl/macs_pkg.sv
`timescale 1ns / 1ps
// Package for the motor axis command slave: command codes, status codes,
// the decoded operation type and the queue payload structs. No dependencies.
package macs_pkg;

	// Command codes as they arrive from the bus master.
	localparam logic [15:0] CMD_PING       = 16'd0;
	localparam logic [15:0] CMD_HOME       = 16'd1;
	localparam logic [15:0] CMD_ENABLE     = 16'd2;
	localparam logic [15:0] CMD_GET_POS    = 16'd6;
	localparam logic [15:0] CMD_GET_TARGET = 16'd7;
	localparam logic [15:0] CMD_GET_ID     = 16'd8;
	localparam logic [15:0] CMD_DRIVE_DIST = 16'd10;
	localparam logic [15:0] CMD_DRIVE_REL  = 16'd11;
	localparam logic [15:0] CMD_DRIVE_TO   = 16'd12;
	localparam logic [15:0] CMD_SPEED      = 16'd15;
	localparam logic [15:0] CMD_ZONE       = 16'd16;
	localparam logic [15:0] CMD_REACHED    = 16'd20;

	localparam int unsigned SLAVE_ID_W    = 15;
	localparam logic [SLAVE_ID_W-1:0] SLAVE_ID_RESET = 15'd7;
	localparam logic [15:0] ZONE_RESET    = 16'd5;
	localparam logic [7:0]  SPEED_RESET   = 8'd255;

	// Configuration register indexes.
	localparam logic REG_SLAVE_ID = 1'b0;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD     = 2'd1,
		ST_UNKNOWN = 2'd2
	} status_t;

	// Operation after classification in the front part. Invalid data and
	// unknown codes are resolved here so the back part never looks at codes.
	typedef enum logic [3:0] {
		OP_EDGE_UP,
		OP_EDGE_DN,
		OP_PING,
		OP_HOME,
		OP_ENABLE,
		OP_GET_POS,
		OP_GET_TGT,
		OP_GET_ID,
		OP_DRIVE_DIST,
		OP_DRIVE_REL,
		OP_DRIVE_TO,
		OP_SPEED,
		OP_ZONE,
		OP_REACHED,
		OP_BAD_DATA,
		OP_UNKNOWN
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] data;
	} cmd_t;

	typedef struct packed {
		logic [15:0] reply_value;
		logic        has_reply;
		status_t     status;
		logic        drive_enable;
		logic [7:0]  speed_limit;
	} res_t;

endpackage

FILE: rtl/macs_fifo.sv
`timescale 1ns / 1ps
// Small generic first-in first-out queue built from registers.
// No package dependencies.
module macs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign rdata   = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

FILE: rtl/macs_front.sv
`timescale 1ns / 1ps
// Front part: takes input items and classifies them into operations,
// checking data ranges. Depends on macs_pkg.
module macs_front (
	input  logic               event_kind,
	input  logic [15:0]        command,
	input  logic signed [15:0] data,
	input  logic               enc_a,
	input  logic               enc_b,
	output macs_pkg::cmd_t     cmd
);
	import macs_pkg::*;

	logic enable_ok;
	logic speed_ok;
	op_t  op;

	// Enable takes only 0 or 1; speed takes 0..255, so the upper byte is zero.
	assign enable_ok = (data == 16'sd0) || (data == 16'sd1);
	assign speed_ok  = (data[15:8] == 8'd0);

	always_comb begin
		if (!event_kind) begin
			op = (enc_a == enc_b) ? OP_EDGE_UP : OP_EDGE_DN;
		end else begin
			unique case (command)
				CMD_PING:       op = OP_PING;
				CMD_HOME:       op = OP_HOME;
				CMD_ENABLE:     op = enable_ok ? OP_ENABLE : OP_BAD_DATA;
				CMD_GET_POS:    op = OP_GET_POS;
				CMD_GET_TARGET: op = OP_GET_TGT;
				CMD_GET_ID:     op = OP_GET_ID;
				CMD_DRIVE_DIST: op = OP_DRIVE_DIST;
				CMD_DRIVE_REL:  op = OP_DRIVE_REL;
				CMD_DRIVE_TO:   op = OP_DRIVE_TO;
				CMD_SPEED:      op = speed_ok ? OP_SPEED : OP_BAD_DATA;
				CMD_ZONE:       op = OP_ZONE;
				CMD_REACHED:    op = OP_REACHED;
				default:        op = OP_UNKNOWN;
			endcase
		end
	end

	assign cmd.op   = op;
	assign cmd.data = data;

endmodule

FILE: rtl/macs_back.sv
`timescale 1ns / 1ps
// Back part: holds the axis state and carries out one classified operation
// per cycle while results have room, giving its result. Depends on macs_pkg.
module macs_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_avail,
	input  macs_pkg::cmd_t                      cmd,
	input  logic                                res_full,
	input  logic [macs_pkg::SLAVE_ID_W-1:0]     slave_id,
	output logic                                exec,
	output macs_pkg::res_t                      res
);
	import macs_pkg::*;

	logic [15:0] pos_q, pos_n;
	logic [15:0] tgt_q, tgt_n;
	logic [15:0] zone_q, zone_n;
	logic [7:0]  speed_q, speed_n;
	logic        en_q, en_n;

	logic [15:0]        diff;
	logic signed [16:0] d_ext;
	logic signed [16:0] z_ext;
	logic signed [16:0] z_neg;
	logic               hit;

	logic [15:0] reply;
	logic        has_reply;
	status_t     status;

	assign exec = cmd_avail && !res_full;

	// Reach window: -zone < (target - position) < zone, with the negated
	// zone taken at 17 bits so the most negative zone does not wrap.
	assign diff  = tgt_q - pos_q;
	assign d_ext = $signed({diff[15], diff});
	assign z_ext = $signed({zone_q[15], zone_q});
	assign z_neg = -z_ext;
	assign hit   = (z_neg < d_ext) && (d_ext < z_ext);

	always_comb begin
		pos_n     = pos_q;
		tgt_n     = tgt_q;
		zone_n    = zone_q;
		speed_n   = speed_q;
		en_n      = en_q;
		reply     = '0;
		has_reply = 1'b0;
		status    = ST_OK;
		unique case (cmd.op)
			OP_EDGE_UP:    pos_n = pos_q + 16'd1;
			OP_EDGE_DN:    pos_n = pos_q - 16'd1;
			OP_PING: begin
				reply     = cmd.data;
				has_reply = 1'b1;
			end
			OP_HOME: begin
				pos_n = '0;
				tgt_n = '0;
				en_n  = 1'b1;
			end
			OP_ENABLE: begin
				tgt_n = pos_q;
				en_n  = cmd.data[0];
			end
			OP_GET_POS: begin
				reply     = pos_q;
				has_reply = 1'b1;
			end
			OP_GET_TGT: begin
				reply     = tgt_q;
				has_reply = 1'b1;
			end
			OP_GET_ID: begin
				reply     = {1'b0, slave_id};
				has_reply = 1'b1;
			end
			OP_DRIVE_DIST: tgt_n = tgt_q + cmd.data;
			OP_DRIVE_REL:  tgt_n = pos_q + cmd.data;
			OP_DRIVE_TO:   tgt_n = cmd.data;
			OP_SPEED:      speed_n = cmd.data[7:0];
			OP_ZONE:       zone_n = cmd.data;
			OP_REACHED: begin
				reply     = {15'd0, hit};
				has_reply = 1'b1;
			end
			OP_BAD_DATA:   status = ST_BAD;
			OP_UNKNOWN:    status = ST_UNKNOWN;
		endcase
	end

	assign res.reply_value  = reply;
	assign res.has_reply    = has_reply;
	assign res.status       = status;
	assign res.drive_enable = en_n;
	assign res.speed_limit  = speed_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			tgt_q   <= '0;
			zone_q  <= ZONE_RESET;
			speed_q <= SPEED_RESET;
			en_q    <= 1'b1;
		end else if (exec) begin
			pos_q   <= pos_n;
			tgt_q   <= tgt_n;
			zone_q  <= zone_n;
			speed_q <= speed_n;
			en_q    <= en_n;
		end
	end

endmodule

FILE: rtl/motor_axis_command_slave_top.sv
`timescale 1ns / 1ps
// Top level of the motor axis command slave: front classifier, command queue,
// back executor and result queue. Depends on macs_pkg, macs_front,
// macs_fifo and macs_back.
//
//   Channel   Handshake            Payload
//   --------  -------------------  -------------------------------------------
//   input     push / full          event_kind, command, data, enc_a, enc_b
//   result    pop / empty          reply_value, has_reply, status,
//                                  drive_enable, speed_limit
//   config    psel/penable/pready  paddr, pwrite, pwdata, prdata (slave_id)
//
// One item is accepted per cycle while full is low, and each gives exactly one
// result item. An accepted item is written into the command queue, waits there
// until the back part executes it, and is then written into the result queue,
// from which it can be taken. The back part executes one item per cycle while
// the result queue has room.
// Reset (arst_n low) empties both queues and returns the axis state to
// position 0, target 0, zone 5, speed limit 255, driver enabled, slave id 7.
// When results are not taken, the result queue fills, the back part stops,
// then the command queue fills and full rises; no item is lost.
module motor_axis_command_slave_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	// Input item channel.
	input  logic               push,
	output logic               full,
	input  logic               event_kind,
	input  logic [15:0]        command,
	input  logic signed [15:0] data,
	input  logic               enc_a,
	input  logic               enc_b,
	// Result item channel.
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] reply_value,
	output logic               has_reply,
	output logic [1:0]         status,
	output logic               drive_enable,
	output logic [7:0]         speed_limit,
	// Configuration port.
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import macs_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t                  front_cmd;
	cmd_t                  back_cmd;
	res_t                  back_res;
	res_t                  out_res;
	logic                  mid_empty;
	logic                  out_full;
	logic                  exec;
	logic [CW-1:0]         mid_cnt;
	logic [CW-1:0]         out_cnt;
	logic [SLAVE_ID_W-1:0] slave_id_q;
	logic                  cfg_wr;

	// Configuration register. Registers sit at word addresses, so the
	// register index is paddr[2]; the lower address bits are ignored.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_id_q <= SLAVE_ID_RESET;
		end else if (cfg_wr && (paddr[2] == REG_SLAVE_ID)) begin
			slave_id_q <= pwdata[SLAVE_ID_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_SLAVE_ID) ? {17'd0, slave_id_q} : 32'd0;

	// Front part: decode and range checks, straight into the command queue.
	macs_front u_front (
		.event_kind (event_kind),
		.command    (command),
		.data       (data),
		.enc_a      (enc_a),
		.enc_b      (enc_b),
		.cmd        (front_cmd)
	);

	macs_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_cmd),
		.pop    (exec),
		.rdata  (back_cmd),
		.full   (full),
		.empty  (mid_empty),
		.count  (mid_cnt)
	);

	// Back part: executes one command when the result queue has room.
	macs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (!mid_empty),
		.cmd       (back_cmd),
		.res_full  (out_full),
		.slave_id  (slave_id_q),
		.exec      (exec),
		.res       (back_res)
	);

	macs_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (exec),
		.wdata  (back_res),
		.pop    (pop),
		.rdata  (out_res),
		.full   (out_full),
		.empty  (empty),
		.count  (out_cnt)
	);

	assign reply_value  = out_res.reply_value;
	assign has_reply    = out_res.has_reply;
	assign status       = out_res.status;
	assign drive_enable = out_res.drive_enable;
	assign speed_limit  = out_res.speed_limit;

	// Items inside the block: every accepted item adds one, every taken
	// result removes one, and nothing else changes the total.
	logic [CW:0] in_flight;
	logic        in_acc;
	logic        out_acc;

	assign in_flight = {1'b0, mid_cnt} + {1'b0, out_cnt};
	assign in_acc    = push && !full;
	assign out_acc   = pop && !empty;

	a_item_conservation: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (in_flight == $past(in_flight) + {{CW{1'b0}}, $past(in_acc)}
			- {{CW{1'b0}}, $past(out_acc)}))
		else $error("item count through the queues does not balance");

	a_reply_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !has_reply) |-> (reply_value == 16'sd0))
		else $error("reply word nonzero on a result without reply");

	a_exec_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		exec |-> (!mid_empty && !out_full))
		else $error("back part executed without a command or result room");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the motor axis command slave: directed and random
// encoder edges and master commands, checked against an axis model kept here.
// Depends on macs_pkg and motor_axis_command_slave_top.
module tb_top;
	import macs_pkg::*;

	// Values of the event_kind field.
	localparam logic KIND_EDGE = 1'b0;
	localparam logic KIND_CMD  = 1'b1;

	// Byte address of the slave id register on the configuration port.
	localparam logic [2:0] ADDR_SLAVE_ID = {REG_SLAVE_ID, 2'b00};

	localparam int RANDOM_PHASES    = 4;
	localparam int ITEMS_PER_PHASE  = 375;

	// One input item as the block sees it.
	typedef struct {
		logic               kind;
		logic [15:0]        cmd;
		logic signed [15:0] dat;
		logic               a;
		logic               b;
	} axis_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               push = 1'b0;
	logic               full;
	logic               event_kind = 1'b0;
	logic [15:0]        command = '0;
	logic signed [15:0] data = '0;
	logic               enc_a = 1'b0;
	logic               enc_b = 1'b0;

	logic               empty;
	logic               pop = 1'b0;
	logic signed [15:0] reply_value;
	logic               has_reply;
	logic [1:0]         status;
	logic               drive_enable;
	logic [7:0]         speed_limit;

	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	motor_axis_command_slave_top DUT (.*);

	always #1 clk = ~clk;

	// Items waiting to be sent, and the results the axis model expects, oldest first.
	axis_event_t axis_events_pending[$];
	res_t        expected_replies[$];

	// Axis model state, a copy of what the block should hold after every item.
	logic [15:0] axis_pos;
	logic [15:0] axis_target;
	logic [15:0] zone_width;
	logic [7:0]  speed_cap;
	logic        drive_on;
	logic [14:0] id_value;

	int fail_count = 0;
	int n_edges = 0;
	int n_cmds = 0;
	int n_hits = 0;
	int n_id_writes = 0;

	// Sender and receiver pacing. Each side occasionally flips between a calm
	// stretch with no idle cycles and a stretch with randomly drawn gaps.
	int send_wait = 0;
	int take_wait = 0;
	bit send_calm = 1'b0;
	bit take_calm = 1'b0;

	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(0, 31) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 16);
	endfunction

	// Advances the axis model by one item and returns the result it should give.
	function automatic res_t axis_apply(input axis_event_t ev);
		res_t               r;
		logic signed [15:0] gap;
		int                 gap_i;
		int                 zone_i;
		r.reply_value = '0;
		r.has_reply   = 1'b0;
		r.status      = ST_OK;
		if (ev.kind == KIND_EDGE) begin
			// Equal phases count up, differing phases count down; the position wraps.
			if (ev.a == ev.b)
				axis_pos = axis_pos + 16'd1;
			else
				axis_pos = axis_pos - 16'd1;
			n_edges++;
		end else begin
			n_cmds++;
			case (ev.cmd)
				CMD_PING: begin
					r.reply_value = ev.dat;
					r.has_reply   = 1'b1;
				end
				CMD_HOME: begin
					axis_pos    = '0;
					axis_target = '0;
					drive_on    = 1'b1;
				end
				CMD_ENABLE: begin
					if (ev.dat == 16'sd0 || ev.dat == 16'sd1) begin
						axis_target = axis_pos;
						drive_on    = ev.dat[0];
					end else begin
						r.status = ST_BAD;
					end
				end
				CMD_GET_POS: begin
					r.reply_value = axis_pos;
					r.has_reply   = 1'b1;
				end
				CMD_GET_TARGET: begin
					r.reply_value = axis_target;
					r.has_reply   = 1'b1;
				end
				CMD_GET_ID: begin
					r.reply_value = {1'b0, id_value};
					r.has_reply   = 1'b1;
				end
				CMD_DRIVE_DIST: axis_target = axis_target + ev.dat;
				CMD_DRIVE_REL:  axis_target = axis_pos + ev.dat;
				CMD_DRIVE_TO:   axis_target = ev.dat;
				CMD_SPEED: begin
					if (!ev.dat[15] && ev.dat[15:8] == 8'd0)
						speed_cap = ev.dat[7:0];
					else
						r.status = ST_BAD;
				end
				CMD_ZONE: zone_width = ev.dat;
				CMD_REACHED: begin
					// The distance wraps to 16 bits; the negated zone does not.
					gap    = axis_target - axis_pos;
					gap_i  = int'(gap);
					zone_i = int'($signed(zone_width));
					r.has_reply = 1'b1;
					if (-zone_i < gap_i && gap_i < zone_i) begin
						r.reply_value = 16'sd1;
						n_hits++;
					end
				end
				default: r.status = ST_UNKNOWN;
			endcase
		end
		r.drive_enable = drive_on;
		r.speed_limit  = speed_cap;
		return r;
	endfunction

	task automatic queue_cmd(input logic [15:0] c, input logic signed [15:0] d);
		axis_event_t ev;
		ev.kind = KIND_CMD;
		ev.cmd  = c;
		ev.dat  = d;
		ev.a    = 1'($urandom());
		ev.b    = 1'($urandom());
		axis_events_pending.push_back(ev);
	endtask

	// The command and data fields carry noise on an edge; the block must ignore them.
	task automatic queue_edge(input logic a, input logic b);
		axis_event_t ev;
		ev.kind = KIND_EDGE;
		ev.cmd  = 16'($urandom());
		ev.dat  = 16'($urandom());
		ev.a    = a;
		ev.b    = b;
		axis_events_pending.push_back(ev);
	endtask

	// Random traffic: mostly edges and well-formed commands, with data shaped so
	// that the accepted ranges and the reach test are hit often, plus some
	// out-of-range data and random command codes.
	function automatic axis_event_t random_event();
		axis_event_t ev;
		int          pick;
		pick   = $urandom_range(0, 99);
		ev.cmd = 16'($urandom());
		ev.dat = 16'($urandom());
		ev.a   = 1'($urandom());
		ev.b   = 1'($urandom());
		if (pick < 40) begin
			ev.kind = KIND_EDGE;
		end else if (pick < 94) begin
			ev.kind = KIND_CMD;
			case ($urandom_range(0, 11))
				0:  ev.cmd = CMD_PING;
				1:  ev.cmd = CMD_HOME;
				2: begin
					ev.cmd = CMD_ENABLE;
					if ($urandom_range(0, 3) != 0)
						ev.dat = 16'($urandom_range(0, 1));
				end
				3:  ev.cmd = CMD_GET_POS;
				4:  ev.cmd = CMD_GET_TARGET;
				5:  ev.cmd = CMD_GET_ID;
				6:  ev.cmd = CMD_DRIVE_DIST;
				7:  ev.cmd = CMD_DRIVE_REL;
				8:  ev.cmd = CMD_DRIVE_TO;
				9: begin
					ev.cmd = CMD_SPEED;
					if ($urandom_range(0, 9) < 7)
						ev.dat = 16'($urandom_range(0, 255));
				end
				10: begin
					ev.cmd = CMD_ZONE;
					if ($urandom_range(0, 4) != 0)
						ev.dat = 16'($urandom_range(0, 20));
				end
				default: ev.cmd = CMD_REACHED;
			endcase
			// Short drives keep the target near the position so the reach test
			// answers both ways.
			if ((ev.cmd == CMD_DRIVE_DIST || ev.cmd == CMD_DRIVE_REL ||
					ev.cmd == CMD_DRIVE_TO) && $urandom_range(0, 9) < 7)
				ev.dat = 16'($signed($urandom_range(0, 24)) - 12);
		end else begin
			ev.kind = KIND_CMD;
		end
		return ev;
	endfunction

	// Writes the slave id over the configuration port, then reads it back.
	// The read follows the write directly, so psel stays high between them.
	task automatic write_slave_id(input logic [14:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_SLAVE_ID;
		pwdata  <= {17'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// The register takes the new id at this edge.
		id_value = v;
		n_id_writes++;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {17'd0, v}) begin
			$error("prdata mismatch: expected %h, actual %h", {17'd0, v}, prdata);
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Waits until every queued item has been sent and every result has come back.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (axis_events_pending.size() != 0 || push || expected_replies.size() != 0);
	endtask

	// Driver: sends the pending items in order. An item is taken at an edge with
	// push high and full low; the model is advanced at that same edge. After
	// each item the driver idles for a drawn number of cycles before the next.
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				expected_replies.push_back(axis_apply('{event_kind, command, data,
					enc_a, enc_b}));
			if (!push || !full) begin
				if (send_wait > 0) begin
					send_wait--;
					push <= 1'b0;
				end else if (axis_events_pending.size() != 0) begin
					axis_event_t ev;
					ev = axis_events_pending.pop_front();
					event_kind <= ev.kind;
					command    <= ev.cmd;
					data       <= ev.dat;
					enc_a      <= ev.a;
					enc_b      <= ev.b;
					push       <= 1'b1;
					send_wait  = draw_gap(send_calm);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [15:0] exp,
			input logic [15:0] act);
		if (act !== exp) begin
			$error("%s mismatch: expected %h, actual %h", name, exp, act);
			fail_count++;
		end
	endtask

	// Monitor: takes results with random stalls and compares every field of
	// each one against the oldest expectation.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop && !empty) begin
			if (expected_replies.size() == 0) begin
				$error("result item arrived with nothing expected");
				fail_count++;
			end else begin
				res_t exp;
				exp = expected_replies.pop_front();
				check_field("reply_value", exp.reply_value, reply_value);
				check_field("has_reply", 16'(exp.has_reply), 16'(has_reply));
				check_field("status", 16'(exp.status), 16'(status));
				check_field("drive_enable", 16'(exp.drive_enable), 16'(drive_enable));
				check_field("speed_limit", 16'(exp.speed_limit), 16'(speed_limit));
			end
			take_wait = draw_gap(take_calm);
			if (take_wait == 0) begin
				pop <= 1'b1;
			end else begin
				take_wait--;
				pop <= 1'b0;
			end
		end else if (!pop) begin
			if (take_wait == 0)
				pop <= 1'b1;
			else
				take_wait--;
		end
	end

	// Main sequence: reset, a directed pass at the reset id, then random phases,
	// each one preceded by a new slave id written while the block is idle.
	initial begin
		logic [14:0] ids[RANDOM_PHASES];
		axis_pos    = '0;
		axis_target = '0;
		zone_width  = ZONE_RESET;
		speed_cap   = SPEED_RESET;
		drive_on    = 1'b1;
		id_value    = SLAVE_ID_RESET;
		ids[0] = '0;
		ids[1] = 15'h7FFF;
		ids[2] = 15'($urandom());
		ids[3] = 15'($urandom());

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: data extremes, every command, bad data and unknown codes.
		queue_cmd(CMD_PING, 16'sh7FFF);
		queue_cmd(CMD_PING, -16'sd32768);
		queue_cmd(CMD_GET_ID, 16'sd0);
		queue_edge(1'b0, 1'b0);
		queue_edge(1'b1, 1'b1);
		queue_edge(1'b0, 1'b1);
		queue_edge(1'b1, 1'b0);
		queue_edge(1'b0, 1'b1);      // position wraps below zero
		queue_cmd(CMD_GET_POS, 16'sd0);
		queue_cmd(CMD_REACHED, 16'sd0);
		queue_cmd(CMD_DRIVE_TO, 16'sh7FFF);
		queue_cmd(CMD_REACHED, 16'sd0);
		queue_cmd(CMD_DRIVE_DIST, 16'sd1);    // target wraps to the most negative value
		queue_cmd(CMD_GET_TARGET, 16'sd0);
		queue_cmd(CMD_DRIVE_REL, -16'sd32768);
		queue_cmd(CMD_GET_TARGET, 16'sd0);
		queue_cmd(CMD_ENABLE, 16'sd2);
		queue_cmd(CMD_ENABLE, -16'sd1);
		queue_cmd(CMD_ENABLE, 16'sd0);
		queue_cmd(CMD_ENABLE, 16'sd1);
		queue_cmd(CMD_SPEED, 16'sd256);
		queue_cmd(CMD_SPEED, -16'sd1);
		queue_cmd(CMD_SPEED, 16'sd0);
		queue_cmd(CMD_ZONE, 16'sd0);          // a zone of zero never reports reached
		queue_cmd(CMD_REACHED, 16'sd0);
		queue_cmd(CMD_ZONE, -16'sd32768);     // most negative zone, no wrap on negation
		queue_cmd(CMD_REACHED, 16'sd0);
		queue_cmd(CMD_HOME, 16'sd0);
		queue_cmd(16'd3, 16'sd0);
		queue_cmd(16'hFFFF, 16'sd0);
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_slave_id(ids[p]);
			@(negedge clk);
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				axis_events_pending.push_back(random_event());
			wait_drained();
		end

		// Wait out any stray result before the summary.
		repeat (8) @(negedge clk);
		$display("Covered %0d encoder edges and %0d commands over %0d slave id settings;",
			n_edges, n_cmds, n_id_writes + 1);
		$display("the reach test answered yes %0d times.", n_hits);
		if (fail_count == 0 && expected_replies.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, with every gap and stall at its longest.
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/macs_pkg.sv
rtl/macs_fifo.sv
rtl/macs_front.sv
rtl/macs_back.sv
rtl/motor_axis_command_slave_top.sv
tb/sv/tb_top.sv
